FILE: rtl/core/pse_pkg.sv
`timescale 1ns / 1ps

package pse_pkg;

    // Field and register widths
    localparam int ERR_W      = 12;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int INTEG_W    = 16;
    localparam int GAIN_W     = 12;
    localparam int LIMIT_W    = 15;
    localparam int DEADBAND_W = 11;
    localparam int DRIVE_W    = 16;
    localparam int TDATA_W    = 16;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;

    // Datapath widths: signed gain is one bit wider than the unsigned gain
    localparam int PROD_P_W  = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W  = GAIN_W + 1 + INTEG_W;
    localparam int PROD_D_W  = GAIN_W + 1 + DIFF_W;
    localparam int SUM_W     = PROD_I_W + 1;
    localparam int FRAC_BITS = 8;
    localparam int Q_W       = SUM_W - FRAC_BITS;

    localparam logic signed [SUM_W-1:0] ROUND_BIAS  = SUM_W'((1 << FRAC_BITS) - 1);
    localparam logic signed [Q_W-1:0]   DRIVE_MAX   = Q_W'(32767);
    localparam logic signed [Q_W-1:0]   DRIVE_MIN   = -DRIVE_MAX;

    // Reset values of the registers
    localparam logic [GAIN_W-1:0]     GAIN_P_RST   = GAIN_W'(102);
    localparam logic [GAIN_W-1:0]     GAIN_I_RST   = GAIN_W'(0);
    localparam logic [GAIN_W-1:0]     GAIN_D_RST   = GAIN_W'(512);
    localparam logic [LIMIT_W-1:0]    LIMIT_RST    = LIMIT_W'(100);
    localparam logic [DEADBAND_W-1:0] DEADBAND_RST = DEADBAND_W'(2);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_P   = 3'd0,
        REG_GAIN_I   = 3'd1,
        REG_GAIN_D   = 3'd2,
        REG_LIMIT    = 3'd3,
        REG_DEADBAND = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0]     gain_p;
        logic [GAIN_W-1:0]     gain_i;
        logic [GAIN_W-1:0]     gain_d;
        logic [LIMIT_W-1:0]    integral_limit;
        logic [DEADBAND_W-1:0] deadband;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [DIFF_W-1:0]  diff;
        logic signed [INTEG_W-1:0] integ;
    } err_stage_t;

    typedef struct packed {
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_I_W-1:0] prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
    } prod_stage_t;

endpackage

FILE: rtl/core/pse_regs.sv
`timescale 1ns / 1ps

module pse_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pse_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pse_pkg::CFG_DATA_W-1:0]    cfg_data,
    output pse_pkg::cfg_t                     cfg
);

    pse_pkg::cfg_t cfg_reg;
    pse_pkg::cfg_t cfg_next;

    // Registers are always writable
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the write transaction; unknown indexes leave all registers alone
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (pse_pkg::cfg_reg_t'(cfg_index))
                pse_pkg::REG_GAIN_P:   cfg_next.gain_p = cfg_data[pse_pkg::GAIN_W-1:0];
                pse_pkg::REG_GAIN_I:   cfg_next.gain_i = cfg_data[pse_pkg::GAIN_W-1:0];
                pse_pkg::REG_GAIN_D:   cfg_next.gain_d = cfg_data[pse_pkg::GAIN_W-1:0];
                pse_pkg::REG_LIMIT:
                    cfg_next.integral_limit = cfg_data[pse_pkg::LIMIT_W-1:0];
                pse_pkg::REG_DEADBAND:
                    cfg_next.deadband = cfg_data[pse_pkg::DEADBAND_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= pse_pkg::GAIN_P_RST;
            cfg_reg.gain_i         <= pse_pkg::GAIN_I_RST;
            cfg_reg.gain_d         <= pse_pkg::GAIN_D_RST;
            cfg_reg.integral_limit <= pse_pkg::LIMIT_RST;
            cfg_reg.deadband       <= pse_pkg::DEADBAND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/pse_integ.sv
`timescale 1ns / 1ps

module pse_integ
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [pse_pkg::ERR_W-1:0]     err_in,
    input  logic [pse_pkg::LIMIT_W-1:0]          integral_limit,
    input  logic [pse_pkg::DEADBAND_W-1:0]       deadband,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output pse_pkg::err_stage_t                  out_data
);

    localparam int SUM_W = pse_pkg::INTEG_W + 1;

    logic                                  valid_reg;
    logic                                  valid_next;
    pse_pkg::err_stage_t                   data_reg;
    pse_pkg::err_stage_t                   data_next;
    logic signed [pse_pkg::ERR_W-1:0]      last_error_reg;
    logic signed [pse_pkg::INTEG_W-1:0]    accum_reg;
    logic                                  accept;
    logic [pse_pkg::ERR_W-1:0]             abs_err;
    logic signed [SUM_W-1:0]               integ_sum;
    logic signed [SUM_W-1:0]               lim_pos;
    logic signed [SUM_W-1:0]               lim_neg;
    logic signed [SUM_W-1:0]               integ_clamped;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Difference, integral update with deadband clear and symmetric clamp
    always_comb
    begin
        abs_err   = err_in[pse_pkg::ERR_W-1] ? (~err_in + pse_pkg::ERR_W'(1)) : err_in;
        integ_sum = SUM_W'(accum_reg) + SUM_W'(err_in);
        lim_pos   = $signed({2'b00, integral_limit});
        lim_neg   = -lim_pos;
        if (abs_err < {1'b0, deadband})
            integ_clamped = '0;
        else
            integ_clamped = integ_sum;
        if (integ_clamped > lim_pos)
            integ_clamped = lim_pos;
        else if (integ_clamped < lim_neg)
            integ_clamped = lim_neg;

        data_next.err   = err_in;
        data_next.diff  = pse_pkg::DIFF_W'(err_in) - pse_pkg::DIFF_W'(last_error_reg);
        data_next.integ = integ_clamped[pse_pkg::INTEG_W-1:0];

        valid_next = accept ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    // Hold the loop state and the stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            last_error_reg <= '0;
            accum_reg      <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                last_error_reg <= err_in;
                accum_reg      <= data_next.integ;
            end
        end
    end

    // Capture the payload on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: rtl/core/pse_prod.sv
`timescale 1ns / 1ps

module pse_prod
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pse_pkg::err_stage_t           in_data,
    input  logic [pse_pkg::GAIN_W-1:0]    gain_p,
    input  logic [pse_pkg::GAIN_W-1:0]    gain_i,
    input  logic [pse_pkg::GAIN_W-1:0]    gain_d,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pse_pkg::prod_stage_t          out_data
);

    logic                                   valid_reg;
    logic                                   valid_next;
    pse_pkg::prod_stage_t                   data_reg;
    pse_pkg::prod_stage_t                   data_next;
    logic                                   accept;
    logic signed [pse_pkg::GAIN_W:0]        sgain_p;
    logic signed [pse_pkg::GAIN_W:0]        sgain_i;
    logic signed [pse_pkg::GAIN_W:0]        sgain_d;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Form the three gain products in parallel
    always_comb
    begin
        sgain_p = $signed({1'b0, gain_p});
        sgain_i = $signed({1'b0, gain_i});
        sgain_d = $signed({1'b0, gain_d});
        data_next.prod_p = pse_pkg::PROD_P_W'(sgain_p) * pse_pkg::PROD_P_W'(in_data.err);
        data_next.prod_i = pse_pkg::PROD_I_W'(sgain_i) * pse_pkg::PROD_I_W'(in_data.integ);
        data_next.prod_d = pse_pkg::PROD_D_W'(sgain_d) * pse_pkg::PROD_D_W'(in_data.diff);
        valid_next = accept ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: rtl/core/pse_out.sv
`timescale 1ns / 1ps

module pse_out
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pse_pkg::prod_stage_t                in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [pse_pkg::DRIVE_W-1:0]  drive
);

    logic                                   valid_reg;
    logic                                   valid_next;
    logic signed [pse_pkg::DRIVE_W-1:0]     drive_reg;
    logic signed [pse_pkg::DRIVE_W-1:0]     drive_next;
    logic                                   accept;
    logic signed [pse_pkg::SUM_W-1:0]       sum;
    logic signed [pse_pkg::SUM_W-1:0]       sum_adj;
    logic signed [pse_pkg::Q_W-1:0]         quot;
    logic signed [pse_pkg::Q_W-1:0]         neg;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign drive     = drive_reg;

    // Sum, drop fraction toward zero, negate and saturate
    always_comb
    begin
        sum = pse_pkg::SUM_W'(in_data.prod_p) + pse_pkg::SUM_W'(in_data.prod_i)
            + pse_pkg::SUM_W'(in_data.prod_d);
        sum_adj = sum[pse_pkg::SUM_W-1] ? (sum + pse_pkg::ROUND_BIAS) : sum;
        quot    = sum_adj[pse_pkg::SUM_W-1:pse_pkg::FRAC_BITS];
        neg     = -quot;
        if (neg > pse_pkg::DRIVE_MAX)
            drive_next = pse_pkg::DRIVE_MAX[pse_pkg::DRIVE_W-1:0];
        else if (neg < pse_pkg::DRIVE_MIN)
            drive_next = pse_pkg::DRIVE_MIN[pse_pkg::DRIVE_W-1:0];
        else
            drive_next = neg[pse_pkg::DRIVE_W-1:0];
        valid_next = accept ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            drive_reg <= drive_next;
        end
    end

endmodule

FILE: rtl/core/pid_servo_error_controller.sv
`timescale 1ns / 1ps

// PID servo controller: each transaction on the s_ side carries one signed
// tracking error and yields exactly one negated, saturated drive value on the
// m_ side, in order. The error and clamped integral are updated in the first
// stage, the three gain products are formed in the second, and the sum is
// shifted, negated and saturated into the output register in the third, so
// the block takes one item per clock while the output side is ready; a result
// waits in the output register until the m_ side takes it. A stage holds its
// item while the stage after it is not ready; the integral is updated as each
// item is accepted. Gains are unsigned Q4.8. Write configuration only while
// no item is in flight.

module pid_servo_error_controller
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pse_pkg::TDATA_W-1:0]         s_tdata,   // [11:0] track_error, [15:12] zero
    // Output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pse_pkg::TDATA_W-1:0]         m_tdata,   // [15:0] drive
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pse_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pse_pkg::CFG_DATA_W-1:0]      cfg_data
);

    pse_pkg::cfg_t                        cfg;
    pse_pkg::err_stage_t                  err_data;
    pse_pkg::prod_stage_t                 prod_data;
    logic                                 err_valid;
    logic                                 err_ready;
    logic                                 prod_valid;
    logic                                 prod_ready;
    logic signed [pse_pkg::DRIVE_W-1:0]   drive;
    logic signed [pse_pkg::ERR_W-1:0]     track_error;

    assign track_error = s_tdata[pse_pkg::ERR_W-1:0];
    assign m_tdata     = drive;

    // Configuration registers
    pse_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Error difference and integral state
    pse_integ u_integ
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .err_in         (track_error),
        .integral_limit (cfg.integral_limit),
        .deadband       (cfg.deadband),
        .out_valid      (err_valid),
        .out_ready      (err_ready),
        .out_data       (err_data)
    );

    // Gain products
    pse_prod u_prod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .in_data   (err_data),
        .gain_p    (cfg.gain_p),
        .gain_i    (cfg.gain_i),
        .gain_d    (cfg.gain_d),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    // Output scaling and result register
    pse_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .drive     (drive)
    );

endmodule

FILE: tb/sv/pid_servo_error_controller_tb.sv
`timescale 1ns / 1ps

module pid_servo_error_controller_tb;

    import pse_pkg::*;

    // Expected drive values and the controller state that produces them
    class drive_tracker;
        int gain_p;
        int gain_i;
        int gain_d;
        int limit;
        int deadband;
        int last_err;
        int integ;
        logic [DRIVE_W-1:0] pending_drive[$];
        int mismatches;

        function new();
            gain_p     = GAIN_P_RST;
            gain_i     = GAIN_I_RST;
            gain_d     = GAIN_D_RST;
            limit      = LIMIT_RST;
            deadband   = DEADBAND_RST;
            last_err   = 0;
            integ      = 0;
            mismatches = 0;
        endfunction

        // Mirror one configuration write; unknown indexes leave everything as is
        function void write_register(logic [CFG_INDEX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GAIN_P:   gain_p   = data[GAIN_W-1:0];
                REG_GAIN_I:   gain_i   = data[GAIN_W-1:0];
                REG_GAIN_D:   gain_d   = data[GAIN_W-1:0];
                REG_LIMIT:    limit    = data[LIMIT_W-1:0];
                REG_DEADBAND: deadband = data[DEADBAND_W-1:0];
                default:      ;
            endcase
        endfunction

        // Advance the controller by one error sample and queue its drive value
        function void note_error(logic [TDATA_W-1:0] tdata);
            int err;
            int diff;
            int mag;
            int acc;
            longint sum;
            longint q;
            longint drv;
            err  = $signed(tdata[ERR_W-1:0]);
            diff = err - last_err;
            mag  = (err < 0) ? -err : err;
            acc  = integ + err;
            // Clear inside the deadband, then clamp to the symmetric bound
            if (mag < deadband)
                acc = 0;
            if (acc > limit)
                acc = limit;
            else if (acc < -limit)
                acc = -limit;
            last_err = err;
            integ    = acc;
            sum = longint'(gain_p) * err + longint'(gain_i) * acc + longint'(gain_d) * diff;
            // Truncate toward zero, negate, saturate
            if (sum < 0)
                q = -((-sum) >>> FRAC_BITS);
            else
                q = sum >>> FRAC_BITS;
            drv = -q;
            if (drv > longint'(DRIVE_MAX))
                drv = longint'(DRIVE_MAX);
            else if (drv < -longint'(DRIVE_MAX))
                drv = -longint'(DRIVE_MAX);
            pending_drive.push_back(drv[DRIVE_W-1:0]);
        endfunction

        // Compare one output transaction with the oldest expected drive
        function void check_drive(logic [TDATA_W-1:0] tdata);
            logic [DRIVE_W-1:0] want;
            if (pending_drive.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected drive transaction: actual %0d",
                             $signed(tdata[DRIVE_W-1:0]));
            end
            else
            begin
                want = pending_drive.pop_front();
                if (tdata[DRIVE_W-1:0] !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("drive mismatch: expected %0d, actual %0d",
                                 $signed(want), $signed(tdata[DRIVE_W-1:0]));
                end
            end
        endfunction

        function int outstanding();
            return pending_drive.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_W-1:0]     m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    drive_tracker sb = new();
    int idle_max;

    pid_servo_error_controller dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the handshakes hang
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Observe every transaction on all three channels
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_error(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_drive(m_tdata);
        end
    end

    // Output side: stall a random number of cycles before each result
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever
        begin
            stall = $urandom_range(0, idle_max);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Send one error sample; tvalid stays high until the next gap
    task automatic send_error(input int e);
        logic [TDATA_W-1:0] word;
        int gap;
        word = '0;
        word[ERR_W-1:0] = e[ERR_W-1:0];
        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
    endtask

    // One register write; cfg_valid stays high for a following write
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Fill the bits above a register's width with noise
    function automatic logic [CFG_DATA_W-1:0] pad_random(input int value, input int width);
        logic [CFG_DATA_W-1:0] noise;
        logic [CFG_DATA_W-1:0] mask;
        noise = CFG_DATA_W'($urandom);
        mask  = CFG_DATA_W'((1 << width) - 1);
        return (noise & ~mask) | (CFG_DATA_W'(value) & mask);
    endfunction

    // Drain the pipeline, then load a full register set
    task automatic apply_settings(input int gp, input int gi, input int gd,
                                  input int lim, input int db);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
        // A write to an unused index must not disturb anything
        cfg_write(CFG_INDEX_W'($urandom_range(int'(REG_DEADBAND) + 1,
                                              (1 << CFG_INDEX_W) - 1)),
                  CFG_DATA_W'($urandom));
        cfg_write(REG_GAIN_P,   pad_random(gp,  GAIN_W));
        cfg_write(REG_GAIN_I,   pad_random(gi,  GAIN_W));
        cfg_write(REG_GAIN_D,   pad_random(gd,  GAIN_W));
        cfg_write(REG_LIMIT,    pad_random(lim, LIMIT_W));
        cfg_write(REG_DEADBAND, pad_random(db,  DEADBAND_W));
        cfg_valid <= 1'b0;
    endtask

    // Zero, full scale, a small slice, or anything in range
    function automatic int pick_value(input int maxv);
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return maxv;
            2:       return $urandom_range(0, maxv / 16);
            default: return $urandom_range(0, maxv);
        endcase
    endfunction

    // Mix of uniform, drifting, near-deadband and extreme errors
    function automatic int next_error(input int drift_sign, input int db);
        int e;
        int r;
        r = $urandom_range(0, 9);
        if (r <= 3)
            e = int'($urandom_range(0, 4095)) - 2048;
        else if (r <= 6)
            e = (drift_sign > 0) ? int'($urandom_range(0, 2047))
                                 : -int'($urandom_range(0, 2048));
        else if (r <= 8)
        begin
            e = db + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1))
                e = -e;
            if (e > 2047)
                e = 2047;
            else if (e < -2048)
                e = -2048;
        end
        else
            e = $urandom_range(0, 1) ? 2047 : -2048;
        return e;
    endfunction

    // Main stimulus
    initial
    begin
        int at_reset[10];
        int saturating[5];
        int wide_band[5];
        int zero_limit[3];
        int drift_sign;
        int db;
        at_reset   = '{0, 1, -1, 2, -2, 2047, 2047, -2048, -2048, 0};
        saturating = '{2047, 2047, -2048, -2048, 0};
        wide_band  = '{2046, 2047, -2048, -2047, 2047};
        zero_limit = '{2047, -2048, 1};
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        idle_max = 8;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: deadband edges and the integral clamp
        foreach (at_reset[i])
            send_error(at_reset[i]);
        // Full gains, no deadband: drive saturates both ways
        apply_settings(4095, 4095, 4095, 32767, 0);
        foreach (saturating[i])
            send_error(saturating[i]);
        // Widest deadband: only the two extremes escape clearing
        apply_settings(256, 4095, 0, 32767, 2047);
        foreach (wide_band[i])
            send_error(wide_band[i]);
        // Zero integral limit holds the integral at zero
        apply_settings(4095, 4095, 4095, 0, 0);
        foreach (zero_limit[i])
            send_error(zero_limit[i]);

        // Random phases, each with its own settings and idling
        for (int p = 0; p < 10; p++)
        begin
            db = pick_value(2047);
            if ($urandom_range(0, 1))
                db = $urandom_range(0, 16);
            apply_settings(pick_value(4095), pick_value(4095), pick_value(4095),
                           pick_value(32767), db);
            idle_max   = ($urandom_range(0, 3) == 0) ? 0 : 8;
            drift_sign = $urandom_range(0, 1) ? 1 : -1;
            for (int k = 0; k < 50; k++)
                send_error(next_error(drift_sign, db));
        end

        // Drain and finish
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
